// ===== rtl/jsd_pkg.sv =====
// Shared constants and types for the job sequencing block.
package jsd_pkg;

  localparam int MAX_JOBS_DEF  = 64;
  localparam int MAX_SLOTS_DEF = 32;

  localparam int DL_W   = 6;
  localparam int PF_W   = 16;
  localparam int SLOT_W = 5;
  localparam int ID_W   = 7;
  localparam int SUM_W  = 21;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot_index;
    logic [ID_W-1:0]   chosen_id;
    logic              is_total;
    logic [SUM_W-1:0]  profit_sum;
    logic              end_of_run;
  } emit_t;

endpackage

// ===== rtl/jsd_if.sv =====
// Job input and result output channel interfaces.
interface jsd_in_if;
  logic                        valid;
  logic                        ready;
  logic [jsd_pkg::DL_W-1:0]    job_deadline;
  logic [jsd_pkg::PF_W-1:0]    job_profit;
  logic                        final_job;

  modport source (output valid, job_deadline, job_profit, final_job, input ready);
  modport sink   (input valid, job_deadline, job_profit, final_job, output ready);
endinterface

interface jsd_out_if;
  logic                        valid;
  logic                        ready;
  logic [jsd_pkg::SLOT_W-1:0]  slot_index;
  logic [jsd_pkg::ID_W-1:0]    chosen_id;
  logic                        is_total;
  logic [jsd_pkg::SUM_W-1:0]   profit_sum;
  logic                        end_of_run;

  modport source (output valid, slot_index, chosen_id, is_total, profit_sum, end_of_run,
                  input ready);
  modport sink   (input valid, slot_index, chosen_id, is_total, profit_sum, end_of_run,
                  output ready);
endinterface

// ===== rtl/job_sequencing_with_deadlines.sv =====
// Top level of the job sequencing block: sequencer and registered result output.
// Loading accepts a job beat whenever one is offered in the load state; the final beat starts scheduling.
// Scheduling runs N rounds (N jobs loaded), each a job-store scan (one read port, one
// compare per cycle) followed by a slot walk down from the chosen job's deadline.
// Emit walks all MAX_SLOTS slots, reading out each occupied slot, then sends the total beat.
// Reset clears job count, slot occupancy and running total; no clearing pass is needed.
module job_sequencing_with_deadlines #(
  parameter int MAX_JOBS  = jsd_pkg::MAX_JOBS_DEF,
  parameter int MAX_SLOTS = jsd_pkg::MAX_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  jsd_in_if.sink     in_i,
  jsd_out_if.source  out_o
);

  jsd_pkg::emit_t emit;
  jsd_pkg::emit_t out_q;
  logic           out_vld_q, out_vld_d;
  logic           emit_ready;
  logic           emit_take;

  jsd_ctrl #(
    .MAX_JOBS  (MAX_JOBS),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .emit_o       (emit),
    .emit_ready_i (emit_ready)
  );

  // Output register: take a new beat when empty or when the current one leaves.
  assign emit_ready = !out_vld_q || out_o.ready;
  assign emit_take  = emit.valid && emit_ready;

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit_take) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_take) begin
      out_q <= emit;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.slot_index = out_q.slot_index;
  assign out_o.chosen_id  = out_q.chosen_id;
  assign out_o.is_total   = out_q.is_total;
  assign out_o.profit_sum = out_q.profit_sum;
  assign out_o.end_of_run = out_q.end_of_run;

endmodule

// ===== rtl/jsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module jsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/jsd_ctrl.sv =====
// Sequencer: job load, profit-order selection scans, slot search and slot emit.
module jsd_ctrl #(
  parameter int MAX_JOBS  = jsd_pkg::MAX_JOBS_DEF,
  parameter int MAX_SLOTS = jsd_pkg::MAX_SLOTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  jsd_in_if.sink         in_i,
  output jsd_pkg::emit_t emit_o,
  input  logic           emit_ready_i
);

  localparam int JW   = $clog2(MAX_JOBS);
  localparam int CW   = $clog2(MAX_JOBS + 1);
  localparam int SW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int DLW  = jsd_pkg::DL_W;
  localparam int PFW  = jsd_pkg::PF_W;
  localparam int RW   = DLW + PFW;
  localparam int SUMW = jsd_pkg::SUM_W;

  typedef enum logic [5:0] {
    S_LOAD      = 6'b000001,
    S_SCAN      = 6'b000010,
    S_SEARCH    = 6'b000100,
    S_EMIT_SCAN = 6'b001000,
    S_EMIT_READ = 6'b010000,
    S_TOTAL     = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        jobs_q, jobs_d;
  logic [CW-1:0]        rd_cnt_q, rd_cnt_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [JW-1:0]        cmp_idx_q, cmp_idx_d;
  logic                 found_q, found_d;
  logic [PFW-1:0]       best_p_q, best_p_d;
  logic [JW-1:0]        best_i_q, best_i_d;
  logic [DLW-1:0]       best_dl_q, best_dl_d;
  logic                 first_q, first_d;
  logic [PFW-1:0]       last_p_q, last_p_d;
  logic [JW-1:0]        last_i_q, last_i_d;
  logic [CW-1:0]        rounds_q, rounds_d;
  logic [DLW-1:0]       dl_q, dl_d;
  logic [DLW-1:0]       s_q, s_d;
  logic [MAX_SLOTS-1:0] occ_q, occ_d;
  logic [SUMW-1:0]      total_q, total_d;

  logic           in_acc;
  logic [DLW-1:0] dl_sat;
  logic           job_we, job_re;
  logic [JW-1:0]  job_waddr, job_raddr;
  logic [RW-1:0]  job_wdata, job_rdata;
  logic           own_we, own_re;
  logic [SW-1:0]  own_waddr, own_raddr;
  logic [CW-1:0]  own_wdata, own_rdata;

  logic [PFW-1:0] c_p;
  logic [DLW-1:0] c_dl;
  logic           elig, better, round_end;
  logic [SW-1:0]  slot_idx;
  logic [SUMW:0]  sum_wide;

  assign in_i.ready = (state_q == S_LOAD);
  assign in_acc     = in_i.valid && in_i.ready;

  // Saturate deadlines at the slot count on load.
  assign dl_sat    = (in_i.job_deadline > DLW'(MAX_SLOTS)) ? DLW'(MAX_SLOTS) : in_i.job_deadline;
  assign job_we    = in_acc && (jobs_q < CW'(MAX_JOBS));
  assign job_waddr = jobs_q[JW-1:0];
  assign job_wdata = {dl_sat, in_i.job_profit};

  assign c_p  = job_rdata[PFW-1:0];
  assign c_dl = job_rdata[RW-1:PFW];

  // Next job in order: strictly after the last pick in (profit desc, id asc).
  assign elig   = first_q || (c_p < last_p_q) || ((c_p == last_p_q) && (cmp_idx_q > last_i_q));
  assign better = !found_q || (c_p > best_p_q);

  assign slot_idx = SW'(dl_q - DLW'(1));
  assign sum_wide = {1'b0, total_q} + (SUMW + 1)'(best_p_q);

  always_comb begin
    state_d   = state_q;
    jobs_d    = jobs_q;
    rd_cnt_d  = rd_cnt_q;
    cmp_vld_d = cmp_vld_q;
    cmp_idx_d = cmp_idx_q;
    found_d   = found_q;
    best_p_d  = best_p_q;
    best_i_d  = best_i_q;
    best_dl_d = best_dl_q;
    first_d   = first_q;
    last_p_d  = last_p_q;
    last_i_d  = last_i_q;
    rounds_d  = rounds_q;
    dl_d      = dl_q;
    s_d       = s_q;
    occ_d     = occ_q;
    total_d   = total_q;
    job_re    = 1'b0;
    job_raddr = rd_cnt_q[JW-1:0];
    own_we    = 1'b0;
    own_waddr = slot_idx;
    own_wdata = CW'(best_i_q) + CW'(1);
    own_re    = 1'b0;
    own_raddr = SW'(s_q);
    round_end = 1'b0;
    emit_o    = '0;

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (job_we) begin
            jobs_d = jobs_q + CW'(1);
          end
          if (in_i.final_job) begin
            state_d   = S_SCAN;
            rd_cnt_d  = '0;
            cmp_vld_d = 1'b0;
            found_d   = 1'b0;
            first_d   = 1'b1;
            rounds_d  = '0;
            occ_d     = '0;
            total_d   = '0;
          end
        end
      end

      S_SCAN: begin
        // Issue one read per cycle; compare each beat in the cycle after its read is issued.
        if (rd_cnt_q < jobs_q) begin
          job_re    = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_cnt_q[JW-1:0];
          rd_cnt_d  = rd_cnt_q + CW'(1);
        end else begin
          cmp_vld_d = 1'b0;
        end
        if (cmp_vld_q && elig && better) begin
          found_d   = 1'b1;
          best_p_d  = c_p;
          best_i_d  = cmp_idx_q;
          best_dl_d = c_dl;
        end
        if (!cmp_vld_q && (rd_cnt_q == jobs_q)) begin
          state_d  = S_SEARCH;
          first_d  = 1'b0;
          last_p_d = best_p_q;
          last_i_d = best_i_q;
          dl_d     = best_dl_q;
        end
      end

      S_SEARCH: begin
        // Walk down from the deadline one slot per cycle.
        if (dl_q == '0) begin
          round_end = 1'b1;
        end else if (!occ_q[slot_idx]) begin
          occ_d[slot_idx] = 1'b1;
          own_we          = 1'b1;
          total_d         = (sum_wide > (SUMW + 1)'(jsd_pkg::SUM_MAX)) ?
                            jsd_pkg::SUM_MAX : sum_wide[SUMW-1:0];
          round_end       = 1'b1;
        end else begin
          dl_d = dl_q - DLW'(1);
        end
        if (round_end) begin
          rounds_d = rounds_q + CW'(1);
          if ((rounds_q + CW'(1)) == jobs_q) begin
            state_d = S_EMIT_SCAN;
            s_d     = '0;
          end else begin
            state_d   = S_SCAN;
            rd_cnt_d  = '0;
            cmp_vld_d = 1'b0;
            found_d   = 1'b0;
          end
        end
      end

      S_EMIT_SCAN: begin
        if (s_q == DLW'(MAX_SLOTS)) begin
          state_d = S_TOTAL;
        end else if (occ_q[SW'(s_q)]) begin
          own_re  = 1'b1;
          state_d = S_EMIT_READ;
        end else begin
          s_d = s_q + DLW'(1);
        end
      end

      S_EMIT_READ: begin
        emit_o.valid      = 1'b1;
        emit_o.slot_index = jsd_pkg::SLOT_W'(s_q);
        emit_o.chosen_id  = jsd_pkg::ID_W'(own_rdata);
        if (emit_ready_i) begin
          s_d     = s_q + DLW'(1);
          state_d = S_EMIT_SCAN;
        end
      end

      S_TOTAL: begin
        emit_o.valid      = 1'b1;
        emit_o.is_total   = 1'b1;
        emit_o.profit_sum = total_q;
        emit_o.end_of_run = 1'b1;
        if (emit_ready_i) begin
          jobs_d  = '0;
          state_d = S_LOAD;
        end
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      jobs_q    <= '0;
      rd_cnt_q  <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      first_q   <= 1'b1;
      rounds_q  <= '0;
      dl_q      <= '0;
      s_q       <= '0;
      occ_q     <= '0;
      total_q   <= '0;
    end else begin
      state_q   <= state_d;
      jobs_q    <= jobs_d;
      rd_cnt_q  <= rd_cnt_d;
      cmp_vld_q <= cmp_vld_d;
      found_q   <= found_d;
      first_q   <= first_d;
      rounds_q  <= rounds_d;
      dl_q      <= dl_d;
      s_q       <= s_d;
      occ_q     <= occ_d;
      total_q   <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    best_p_q  <= best_p_d;
    best_i_q  <= best_i_d;
    best_dl_q <= best_dl_d;
    last_p_q  <= last_p_d;
    last_i_q  <= last_i_d;
  end

  // Job store is written only while loading and read only while scanning.
  jsd_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_JOBS)
  ) u_job_ram (
    .clk_i   (clk_i),
    .we_i    (job_we),
    .waddr_i (job_waddr),
    .wdata_i (job_wdata),
    .re_i    (job_re),
    .raddr_i (job_raddr),
    .rdata_o (job_rdata)
  );

  // Slot owners; occ_q marks which entries hold this run's data.
  jsd_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_SLOTS)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (own_waddr),
    .wdata_i (own_wdata),
    .re_i    (own_re),
    .raddr_i (own_raddr),
    .rdata_o (own_rdata)
  );

  a_jobs_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jobs_q <= CW'(MAX_JOBS))
    else $error("job count above store depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    own_we |-> !occ_q[own_waddr])
    else $error("slot owner written into an occupied slot");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (rd_cnt_q <= jobs_q))
    else $error("scan read past loaded jobs");

  a_run_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_TOTAL) && emit_ready_i) |=> ((jobs_q == '0) && (state_q == S_LOAD)))
    else $error("run not cleared after total beat");

endmodule
